>>> hw/rtl/mcmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcmp_pkg;

  // System bytes decoded at once
  localparam logic [7:0] SYS_TUNE     = 8'hF6;
  localparam logic [7:0] SYS_EOX      = 8'hF7;
  localparam logic [7:0] SYS_TICK     = 8'hF8;
  localparam logic [7:0] SYS_START    = 8'hFA;
  localparam logic [7:0] SYS_CONTINUE = 8'hFB;
  localparam logic [7:0] SYS_STOP     = 8'hFC;
  localparam logic [7:0] SYS_SENSE    = 8'hFE;
  localparam logic [7:0] SYS_RESET    = 8'hFF;

  // Channel message types (upper nibble of the status byte)
  localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
  localparam logic [3:0] MSG_POLY_AT    = 4'hA;
  localparam logic [3:0] MSG_CTRL       = 4'hB;
  localparam logic [3:0] MSG_PROGRAM    = 4'hC;
  localparam logic [3:0] MSG_CHAN_AT    = 4'hD;
  localparam logic [3:0] MSG_PITCH_BEND = 4'hE;

  // Controller numbers
  localparam logic [6:0] CC_LOW_END        = 7'h20;
  localparam logic [6:0] CC_MID_START      = 7'h46;
  localparam logic [6:0] CC_MID_END        = 7'h54;
  localparam logic [6:0] CC_ALL_SOUND_OFF  = 7'h78;
  localparam logic [6:0] CC_RESET_ALL      = 7'h79;
  localparam logic [6:0] CC_ALL_NOTES_OFF  = 7'h7B;

  // Event kinds
  localparam logic [3:0] KIND_CLOCK      = 4'd0;
  localparam logic [3:0] KIND_RESET      = 4'd1;
  localparam logic [3:0] KIND_NOTE_OFF   = 4'd2;
  localparam logic [3:0] KIND_NOTE_ON    = 4'd3;
  localparam logic [3:0] KIND_PITCH_BEND = 4'd4;
  localparam logic [3:0] KIND_CHAN_AT    = 4'd5;
  localparam logic [3:0] KIND_ALL_OFF    = 4'd6;
  localparam logic [3:0] KIND_CTRL_RESET = 4'd7;
  localparam logic [3:0] KIND_CONTROLLER = 4'd8;

  // Clock event codes
  localparam logic [3:0] CLK_START    = 4'd0;
  localparam logic [3:0] CLK_STOP     = 4'd1;
  localparam logic [3:0] CLK_CONTINUE = 4'd2;
  localparam logic [3:0] CLK_TICK     = 4'd3;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [3:0] channel_or_code;
    logic [6:0] first_value;
    logic [6:0] second_value;
    logic       event_flag;
  } event_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_stage_t;

endpackage

`default_nettype wire

>>> hw/rtl/mcmp_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mcmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mcmp_event_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mcmp_event_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_kind;
  logic [3:0] channel_or_code;
  logic [6:0] first_value;
  logic [6:0] second_value;
  logic       event_flag;

  modport source (output valid, output event_kind, output channel_or_code,
                  output first_value, output second_value, output event_flag,
                  input ready);
  modport sink   (input valid, input event_kind, input channel_or_code,
                  input first_value, input second_value, input event_flag,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mcmp_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mcmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] channel_enable_mask;

  modport source (output valid, output channel_enable_mask, input ready);
  modport sink   (input valid, input channel_enable_mask, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mcmp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module mcmp_in_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  mcmp_byte_if.sink             rx,
  input  wire logic             take,
  output mcmp_pkg::byte_stage_t stage
);

  logic       valid;
  logic [7:0] rx_byte;

  // Accept a new request when empty or when the held byte moves on
  assign rx.ready = !valid || take;

  // Hold the byte until the decode stage consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      rx_byte <= rx.rx_byte;
    end
  end

  assign stage.valid   = valid;
  assign stage.rx_byte = rx_byte;

endmodule

`default_nettype wire

>>> hw/rtl/mcmp_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mcmp_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] mask,
  output logic             emit,
  output mcmp_pkg::event_t evt
);

  logic [7:0] held_status;
  logic [7:0] status_next;
  logic [1:0] held_count;
  logic [1:0] count_next;
  logic [6:0] held_data [2];
  logic [6:0] data0_next;
  logic [6:0] data1_next;

  logic [6:0] d0;
  logic [6:0] d1;
  logic [1:0] count_inc;
  logic [1:0] need;
  logic       complete;
  logic [3:0] chan;
  logic [3:0] msg;

  // Data bytes as they stand after the incoming byte is appended
  assign d0        = held_count[0] ? held_data[0] : rx_byte[6:0];
  assign d1        = held_count[0] ? rx_byte[6:0] : held_data[1];
  assign count_inc = held_count + 2'd1;
  assign chan      = held_status[3:0];
  assign msg       = held_status[7:4];

  // Number of data bytes the running status needs
  always_comb begin
    case (msg) inside
      mcmp_pkg::MSG_NOTE_OFF, mcmp_pkg::MSG_NOTE_ON, mcmp_pkg::MSG_POLY_AT,
      mcmp_pkg::MSG_PITCH_BEND: begin
        need = 2'd2;
      end
      mcmp_pkg::MSG_PROGRAM, mcmp_pkg::MSG_CHAN_AT: begin
        need = 2'd1;
      end
      mcmp_pkg::MSG_CTRL: begin
        if (d0 < mcmp_pkg::CC_LOW_END ||
            (d0 >= mcmp_pkg::CC_MID_START && d0 < mcmp_pkg::CC_MID_END)) begin
          need = 2'd2;
        end else if (d0 == mcmp_pkg::CC_ALL_SOUND_OFF || d0 == mcmp_pkg::CC_RESET_ALL ||
                     d0 == mcmp_pkg::CC_ALL_NOTES_OFF) begin
          need = 2'd1;
        end else begin
          need = 2'd0;
        end
      end
      default: begin
        need = 2'd0;
      end
    endcase
  end

  assign complete = (need != 2'd0) && (count_inc >= need);

  // Decode one byte against the running status
  always_comb begin
    status_next = held_status;
    count_next  = held_count;
    data0_next  = held_data[0];
    data1_next  = held_data[1];
    emit        = 1'b0;
    evt         = '0;
    if (fire) begin
      unique case (rx_byte) inside
        mcmp_pkg::SYS_TUNE, mcmp_pkg::SYS_SENSE: begin
          emit = 1'b0;
        end
        mcmp_pkg::SYS_EOX: begin
          status_next = 8'h00;
        end
        mcmp_pkg::SYS_TICK: begin
          emit                = 1'b1;
          evt.event_kind      = mcmp_pkg::KIND_CLOCK;
          evt.channel_or_code = mcmp_pkg::CLK_TICK;
        end
        mcmp_pkg::SYS_START: begin
          emit                = 1'b1;
          evt.event_kind      = mcmp_pkg::KIND_CLOCK;
          evt.channel_or_code = mcmp_pkg::CLK_START;
        end
        mcmp_pkg::SYS_CONTINUE: begin
          emit                = 1'b1;
          evt.event_kind      = mcmp_pkg::KIND_CLOCK;
          evt.channel_or_code = mcmp_pkg::CLK_CONTINUE;
        end
        mcmp_pkg::SYS_STOP: begin
          emit                = 1'b1;
          evt.event_kind      = mcmp_pkg::KIND_CLOCK;
          evt.channel_or_code = mcmp_pkg::CLK_STOP;
          evt.event_flag      = 1'b1;
        end
        mcmp_pkg::SYS_RESET: begin
          emit           = 1'b1;
          evt.event_kind = mcmp_pkg::KIND_RESET;
          evt.event_flag = 1'b1;
        end
        default: begin
          if (rx_byte[7]) begin
            // New running status
            status_next = rx_byte;
            count_next  = 2'd0;
          end else if (!held_count[1]) begin
            // Append the data byte; drop it when the buffer is full
            if (held_count[0]) begin
              data1_next = rx_byte[6:0];
            end else begin
              data0_next = rx_byte[6:0];
            end
            count_next = count_inc;
            if (complete) begin
              if (!mask[chan]) begin
                count_next = 2'd0;
              end else begin
                evt.channel_or_code = chan;
                case (msg) inside
                  mcmp_pkg::MSG_NOTE_OFF, mcmp_pkg::MSG_NOTE_ON: begin
                    count_next       = 2'd0;
                    emit             = 1'b1;
                    evt.first_value  = d0;
                    evt.second_value = d1;
                    evt.event_flag   = 1'b1;
                    if (msg == mcmp_pkg::MSG_NOTE_OFF || d1 == 7'd0) begin
                      evt.event_kind = mcmp_pkg::KIND_NOTE_OFF;
                    end else begin
                      evt.event_kind = mcmp_pkg::KIND_NOTE_ON;
                    end
                  end
                  mcmp_pkg::MSG_PITCH_BEND: begin
                    count_next       = 2'd0;
                    emit             = 1'b1;
                    evt.event_kind   = mcmp_pkg::KIND_PITCH_BEND;
                    evt.first_value  = d1;
                    evt.second_value = d0;
                  end
                  mcmp_pkg::MSG_CHAN_AT: begin
                    count_next      = 2'd0;
                    emit            = 1'b1;
                    evt.event_kind  = mcmp_pkg::KIND_CHAN_AT;
                    evt.first_value = d0;
                  end
                  mcmp_pkg::MSG_CTRL: begin
                    count_next = 2'd0;
                    emit       = 1'b1;
                    if (d0 == mcmp_pkg::CC_ALL_SOUND_OFF ||
                        d0 == mcmp_pkg::CC_ALL_NOTES_OFF) begin
                      evt.event_kind = mcmp_pkg::KIND_ALL_OFF;
                      evt.event_flag = 1'b1;
                    end else if (d0 == mcmp_pkg::CC_RESET_ALL) begin
                      evt.event_kind = mcmp_pkg::KIND_CTRL_RESET;
                    end else begin
                      evt.event_kind   = mcmp_pkg::KIND_CONTROLLER;
                      evt.first_value  = d0;
                      evt.second_value = d1;
                    end
                  end
                  default: begin
                    // program change and poly aftertouch: keep the count
                    emit = 1'b0;
                  end
                endcase
              end
            end
          end
        end
      endcase
    end
  end

  // Hold the running status and count
  always_ff @(posedge clk) begin
    if (rst) begin
      held_status <= 8'h00;
      held_count  <= 2'd0;
    end else begin
      held_status <= status_next;
      held_count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    held_data[0] <= data0_next;
    held_data[1] <= data1_next;
  end

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (held_status == 8'h00 && held_count == 2'd0))
    else $error("running status not cleared by reset");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("data count out of range");

  a_eox_clears: assert property (@(posedge clk)
    (fire && rx_byte == mcmp_pkg::SYS_EOX) |=> held_status == 8'h00)
    else $error("end of exclusive left running status");

  a_channel_event_clears: assert property (@(posedge clk)
    (emit && evt.event_kind != mcmp_pkg::KIND_CLOCK &&
     evt.event_kind != mcmp_pkg::KIND_RESET) |=> held_count == 2'd0)
    else $error("channel event did not clear data count");

endmodule

`default_nettype wire

>>> hw/rtl/mcmp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module mcmp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire mcmp_pkg::event_t evt_in,
  output logic                  take,
  mcmp_event_if.source          ev
);

  logic             valid;
  mcmp_pkg::event_t evt;

  // Room for a new result when empty or when the held one leaves
  assign take = !valid || ev.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ev.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      evt <= evt_in;
    end
  end

  assign ev.valid           = valid;
  assign ev.event_kind      = evt.event_kind;
  assign ev.channel_or_code = evt.channel_or_code;
  assign ev.first_value     = evt.first_value;
  assign ev.second_value    = evt.second_value;
  assign ev.event_flag      = evt.event_flag;

endmodule

`default_nettype wire

>>> hw/rtl/midi_channel_message_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                            Request when
// rx       in   rx_byte[7:0]                                       valid & ready
// ev       out  event_kind, channel_or_code, first_value,          valid & ready
//               second_value, event_flag
// cfg      in   channel_enable_mask[15:0]                          valid & ready
//
// One byte per cycle while the output is not stalled; a byte lands in the input
// register at its request and its result enters the output register when decode
// takes it; decode against the running status sits between the two registers.
// Reset (rst, synchronous) clears running status, data count and mask.
// A stalled result holds the output register; the input register still
// takes a byte while decode has room, so the input stalls only when both
// registers are full. Bytes that cause no event leave no result.
// Configuration writes are taken in every cycle.

module midi_channel_message_parser_unit (
  input  wire logic    clk,
  input  wire logic    rst,
  mcmp_byte_if.sink    rx,
  mcmp_event_if.source ev,
  mcmp_cfg_if.sink     cfg
);

  logic [15:0]           channel_enable_mask;
  mcmp_pkg::byte_stage_t stage;
  mcmp_pkg::event_t      evt;
  logic                  take;
  logic                  fire;
  logic                  emit;

  // Take configuration writes at once
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable_mask <= 16'h0000;
    end else if (cfg.valid && cfg.ready) begin
      channel_enable_mask <= cfg.channel_enable_mask;
    end
  end

  assign fire = stage.valid && take;

  mcmp_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .take  (take),
    .stage (stage)
  );

  mcmp_core u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .rx_byte (stage.rx_byte),
    .mask    (channel_enable_mask),
    .emit    (emit),
    .evt     (evt)
  );

  mcmp_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (emit),
    .evt_in (evt),
    .take   (take),
    .ev     (ev)
  );

endmodule

`default_nettype wire
